FILE: rtl/iroom_pkg.sv
// ----------------------------------------------------------------------------
// Interval room allocator package
// Shared sizes, the heap entry type, the memory port types, the sequencer states and the heap order.
// ----------------------------------------------------------------------------
package iroom_pkg;

   // Sizes of the heap and of the time values.
   localparam int MAX_ROOMS = 256;
   localparam int TIME_BITS = 32;

   // Derived widths: heap index, room count and child index arithmetic.
   localparam int IDX_W   = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
   localparam int CNT_W   = $clog2(MAX_ROOMS + 1);
   localparam int CHILD_W = IDX_W + 2;

   // Fixed port widths.
   localparam int REQ_TIME_W = 32;
   localparam int TAG_W      = 16;
   localparam int ROOM_OUT_W = 9;

   // One heap entry: the end time of a room's last booking and the room.
   typedef struct packed {
      logic [TIME_BITS-1:0] end_time;
      logic [CNT_W-1:0]     room;
   } heap_entry_type;

   // Write port of the heap memory.
   typedef struct packed {
      logic           en;
      logic [IDX_W-1:0] addr;
      heap_entry_type data;
   } heap_wr_type;

   // Two read addresses of the heap memory.
   typedef struct packed {
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
   } heap_rd_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOP,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESULT
   } state_type;

   // Heap order: earlier end first, then lower room number.
   function automatic logic key_less(heap_entry_type a, heap_entry_type b);
      logic res;
      if (a.end_time != b.end_time) begin
         res = (a.end_time < b.end_time);
      end else begin
         res = (a.room < b.room);
      end
      return res;
   endfunction

endpackage

FILE: rtl/iroom_heap_ram.sv
// ----------------------------------------------------------------------------
// Heap memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module iroom_heap_ram (
   input  logic                    clock,
   input  iroom_pkg::heap_wr_type  wr,
   input  iroom_pkg::heap_rd_type  rd,
   output iroom_pkg::heap_entry_type rd_a_data,
   output iroom_pkg::heap_entry_type rd_b_data
);
   import iroom_pkg::*;

   heap_entry_type mem [MAX_ROOMS];
   heap_entry_type rd_a_ff;
   heap_entry_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd.addr_a];
      rd_b_ff <= mem[rd.addr_b];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: rtl/interval_room_allocator.sv
// ----------------------------------------------------------------------------
// Interval room allocator
// Greedy room assignment over a min-heap of (end time, room) kept in memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy stays high until
// the request's single result has been shown on the rsp_ ports for one cycle
// with rsp_valid high, and the receiver must take it then. An overflowing
// request goes from the top check straight to the result. Any other request
// sifts its entry up or down the heap, with a memory read state and then a
// compare and write-back state for each heap level that the entry passes. Busy
// drops in the idle state, where the next request is taken, so a new request
// is not taken before the last one's result has been shown. No clearing pass
// is needed after reset.
module interval_room_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [iroom_pkg::REQ_TIME_W-1:0]   req_start_time,
   input  logic [iroom_pkg::REQ_TIME_W-1:0]   req_end_time,
   input  logic [iroom_pkg::TAG_W-1:0]        req_guest_tag,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   output logic [iroom_pkg::TAG_W-1:0]        rsp_tag_out,
   output logic [iroom_pkg::ROOM_OUT_W-1:0]   rsp_room_number,
   output logic [iroom_pkg::ROOM_OUT_W-1:0]   rsp_rooms_in_use,
   output logic                               rsp_overflow,
   output logic                               rsp_last_out
);
   import iroom_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   heap_entry_type       key_ff, key_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic                 last_ff, last_in;
   logic [CNT_W-1:0]     room_ff, room_in;
   logic                 ovf_ff, ovf_in;

   heap_wr_type          wr;
   heap_rd_type          rd;
   heap_entry_type       rd_a_data;
   heap_entry_type       rd_b_data;

   logic [CHILD_W-1:0]   left_idx;
   logic [CHILD_W-1:0]   right_idx;
   logic [CHILD_W-1:0]   size_ext;
   logic                 left_ok;
   logic                 right_ok;
   logic                 left_lt_key;
   logic                 right_lt_key;
   logic                 right_lt_left;
   logic [IDX_W-1:0]     parent_idx;

   // Heap memory.
   iroom_heap_ram u_heap_ram (
      .clock     (clock),
      .wr        (wr),
      .rd        (rd),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Child and parent positions of the current hole.
   assign left_idx   = CHILD_W'({pos_ff, 1'b0}) + CHILD_W'(1);
   assign right_idx  = left_idx + CHILD_W'(1);
   assign size_ext   = CHILD_W'(count_ff);
   assign left_ok    = (left_idx < size_ext);
   assign right_ok   = (right_idx < size_ext);
   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;

   // The three orderings needed to pick the smallest of key and two children.
   assign left_lt_key   = key_less(rd_a_data, key_ff);
   assign right_lt_key  = key_less(rd_b_data, key_ff);
   assign right_lt_left = key_less(rd_b_data, rd_a_data);

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Request and working registers.
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      key_ff   <= key_in;
      start_ff <= start_in;
      tag_ff   <= tag_in;
      last_ff  <= last_in;
      room_ff  <= room_in;
      ovf_ff   <= ovf_in;
   end

   // Sequencer: top check, then sift up for a new room, sift down for reuse, or straight to the result on overflow.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      start_in  = start_ff;
      tag_in    = tag_ff;
      last_in   = last_ff;
      room_in   = room_ff;
      ovf_in    = ovf_ff;
      wr.en     = 1'b0;
      wr.addr   = pos_ff;
      wr.data   = key_ff;
      rd.addr_a = '0;
      rd.addr_b = '0;

      case (state_ff)
         ST_IDLE: begin
            // The top entry is read while the request is taken.
            if (start) begin
               start_in = TIME_BITS'(req_start_time);
               key_in.end_time = TIME_BITS'(req_end_time);
               tag_in   = req_guest_tag;
               last_in  = req_is_last;
               state_in = ST_TOP;
            end
         end

         ST_TOP: begin
            ovf_in = 1'b0;
            if (count_ff == '0 || rd_a_data.end_time >= start_ff) begin
               if (count_ff == CNT_W'(MAX_ROOMS)) begin
                  // All rooms taken: the request is dropped.
                  ovf_in   = 1'b1;
                  room_in  = '0;
                  state_in = ST_RESULT;
               end else begin
                  // Open a new room at the bottom of the heap.
                  count_in    = count_ff + CNT_W'(1);
                  room_in     = count_ff + CNT_W'(1);
                  key_in.room = count_ff + CNT_W'(1);
                  pos_in      = IDX_W'(count_ff);
                  state_in    = ST_UP_RD;
               end
            end else begin
               // Reuse the top room; its new end sinks from the root.
               room_in     = rd_a_data.room;
               key_in.room = rd_a_data.room;
               pos_in      = '0;
               state_in    = ST_DN_RD;
            end
         end

         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr.en    = 1'b1;
               state_in = ST_RESULT;
            end else begin
               rd.addr_a = parent_idx;
               state_in  = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr.en = 1'b1;
            if (key_less(key_ff, rd_a_data)) begin
               // Parent moves down into the hole.
               wr.data  = rd_a_data;
               pos_in   = parent_idx;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_RESULT;
            end
         end

         ST_DN_RD: begin
            if (!left_ok) begin
               wr.en    = 1'b1;
               state_in = ST_RESULT;
            end else begin
               rd.addr_a = left_idx[IDX_W-1:0];
               rd.addr_b = right_idx[IDX_W-1:0];
               state_in  = ST_DN_CMP;
            end
         end

         ST_DN_CMP: begin
            wr.en = 1'b1;
            if (right_ok && right_lt_key && (!left_lt_key || right_lt_left)) begin
               // Right child is the smallest and moves up.
               wr.data  = rd_b_data;
               pos_in   = right_idx[IDX_W-1:0];
               state_in = ST_DN_RD;
            end else if (left_lt_key) begin
               // Left child is the smallest and moves up.
               wr.data  = rd_a_data;
               pos_in   = left_idx[IDX_W-1:0];
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            // The last request of a batch empties the heap.
            if (last_ff) begin
               count_in = '0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake and result ports.
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESULT);
   assign rsp_tag_out      = tag_ff;
   assign rsp_room_number  = ROOM_OUT_W'(room_ff);
   assign rsp_rooms_in_use = ROOM_OUT_W'(count_ff);
   assign rsp_overflow     = ovf_ff;
   assign rsp_last_out     = last_ff;

endmodule

FILE: bench/interval_room_allocator_tb.sv
// ----------------------------------------------------------------------------
// Interval room allocator testbench
// Drives batches of booking requests through the start/busy handshake and
// checks every result strobe against a min-heap allocator model or a typed row.
// A short table of directed requests comes first, then random batches: mostly
// well-formed sorted batches, some broken or fully random ones, and two
// batches large enough to fill every room and run into overflow.
// ----------------------------------------------------------------------------
module interval_room_allocator_tb;
   import iroom_pkg::*;

   // Timing and run length.
   localparam int GAP_MAX        = 13;
   localparam int RANDOM_ITEMS   = 720;
   localparam int DRAIN_CYCLES   = 25;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_ROWS  = 20;
   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   // Kinds of random batches.
   typedef enum int {
      BATCH_SORTED,
      BATCH_BROKEN,
      BATCH_NOISE
   } batch_kind_type;

   // One request, with an optional hand-written expectation.
   typedef struct packed {
      logic [31:0] arr;
      logic [31:0] dep;
      logic [15:0] tag;
      logic        last;
      logic        typed;
      logic [8:0]  room;
      logic [8:0]  in_use;
      logic        ovf;
   } booking_row_type;

   // One expected result.
   typedef struct packed {
      logic [15:0] tag;
      logic [8:0]  room;
      logic [8:0]  in_use;
      logic        ovf;
      logic        last;
   } room_result_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [REQ_TIME_W-1:0]   req_start_time;
   logic [REQ_TIME_W-1:0]   req_end_time;
   logic [TAG_W-1:0]        req_guest_tag;
   logic                    req_is_last;
   logic                    rsp_valid;
   logic [TAG_W-1:0]        rsp_tag_out;
   logic [ROOM_OUT_W-1:0]   rsp_room_number;
   logic [ROOM_OUT_W-1:0]   rsp_rooms_in_use;
   logic                    rsp_overflow;
   logic                    rsp_last_out;

   // Allocator state as the testbench sees it.
   heap_entry_type room_heap [MAX_ROOMS];
   int             open_rooms;

   room_result_type   pending_results [$];
   booking_row_type   booking_batch [$];

   int  failures;
   int  request_count;
   int  result_count;
   int  overflow_count;
   int  batch_count;
   int  peak_rooms;
   int  idle_cycles;
   bit  no_gaps;

   // Directed requests. Rows with typed set carry their expected result.
   booking_row_type directed_plan [DIRECTED_ROWS] = '{
      // Fresh batch after reset, equal start and end, reuse of the top room.
      '{32'd0, 32'd0, 16'h0000, 1'b0, 1'b1, 9'd1, 9'd1, 1'b0},
      '{32'd0, 32'd5, 16'hFFFF, 1'b0, 1'b1, 9'd2, 9'd2, 1'b0},
      '{32'd1, 32'd3, 16'h0001, 1'b0, 1'b1, 9'd1, 9'd2, 1'b0},
      '{32'd3, 32'd9, 16'h0002, 1'b0, 1'b1, 9'd3, 9'd3, 1'b0},
      '{32'd4, 32'd4, 16'h0003, 1'b0, 1'b1, 9'd1, 9'd3, 1'b0},
      '{32'd6, 32'd7, 16'h0004, 1'b1, 1'b1, 9'd1, 9'd3, 1'b0},
      // Extreme times, then an out-of-order request closing the batch.
      '{TIME_MAX, TIME_MAX, 16'hA5A5, 1'b0, 1'b1, 9'd1, 9'd1, 1'b0},
      '{TIME_MAX, TIME_MAX, 16'h5A5A, 1'b0, 1'b1, 9'd2, 9'd2, 1'b0},
      '{TIME_MAX, 32'd0, 16'h1234, 1'b0, 1'b1, 9'd3, 9'd3, 1'b0},
      '{32'd1, 32'd2, 16'h4321, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      // Equal end times: ties are broken by the lower room number.
      '{32'd10, 32'd20, 16'h0010, 1'b0, 1'b1, 9'd1, 9'd1, 1'b0},
      '{32'd10, 32'd20, 16'h0011, 1'b0, 1'b1, 9'd2, 9'd2, 1'b0},
      '{32'd10, 32'd20, 16'h0012, 1'b0, 1'b1, 9'd3, 9'd3, 1'b0},
      '{32'd21, 32'd30, 16'h0013, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{32'd21, 32'd25, 16'h0014, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{32'd22, 32'd22, 16'h0015, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0},
      // Single-request batches back to back, then a batch of two.
      '{32'd5, 32'd1, 16'h7FFF, 1'b1, 1'b1, 9'd1, 9'd1, 1'b0},
      '{32'd0, 32'd0, 16'h8000, 1'b1, 1'b1, 9'd1, 9'd1, 1'b0},
      '{32'h1234_5678, 32'h8765_4321, 16'hC3C3, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 16'h3C3C, 1'b1, 1'b0, 9'd0, 9'd0, 1'b0}
   };

   interval_room_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_start_time   (req_start_time),
      .req_end_time     (req_end_time),
      .req_guest_tag    (req_guest_tag),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_tag_out      (rsp_tag_out),
      .rsp_room_number  (rsp_room_number),
      .rsp_rooms_in_use (rsp_rooms_in_use),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_out     (rsp_last_out)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Heap order: earlier end time first, lower room number on a tie.
   function automatic bit entry_before(heap_entry_type a, heap_entry_type b);
      return (a.end_time < b.end_time) ||
             (a.end_time == b.end_time && a.room < b.room);
   endfunction

   // Request order inside a well-formed batch: by start time, then end time.
   function automatic bit row_after(booking_row_type a, booking_row_type b);
      return (a.arr > b.arr) || (a.arr == b.arr && a.dep > b.dep);
   endfunction

   // Adds without wrapping past the largest time.
   function automatic logic [31:0] time_add(logic [31:0] a, int unsigned b);
      logic [32:0] total;
      total = {1'b0, a} + 33'(b);
      return total[32] ? TIME_MAX : total[31:0];
   endfunction

   // Assigns a room to one request and updates the heap, greedy style.
   task automatic assign_room(input logic [31:0] arr, input logic [31:0] dep,
                              input logic [15:0] tag, input logic last,
                              output room_result_type res);
      heap_entry_type fresh;
      heap_entry_type held;
      int             pos;
      int             parent;
      int             lchild;
      int             best;
      bit             moving;
      res.tag  = tag;
      res.last = last;
      res.room = '0;
      res.ovf  = 1'b0;
      if (open_rooms == 0 || room_heap[0].end_time >= arr) begin
         // The earliest room is still occupied at this start: open a new one.
         if (open_rooms >= MAX_ROOMS) begin
            res.ovf = 1'b1;
         end else begin
            pos = open_rooms;
            open_rooms++;
            fresh.end_time = dep;
            fresh.room     = CNT_W'(open_rooms);
            res.room       = ROOM_OUT_W'(open_rooms);
            room_heap[pos] = fresh;
            moving = 1'b1;
            while (moving && pos > 0) begin
               parent = (pos - 1) / 2;
               if (entry_before(room_heap[pos], room_heap[parent])) begin
                  held              = room_heap[pos];
                  room_heap[pos]    = room_heap[parent];
                  room_heap[parent] = held;
                  pos = parent;
               end else begin
                  moving = 1'b0;
               end
            end
         end
      end else begin
         // The earliest room is free again: reuse it and push it down.
         res.room = room_heap[0].room;
         room_heap[0].end_time = dep;
         pos = 0;
         moving = 1'b1;
         while (moving) begin
            lchild = 2 * pos + 1;
            best = pos;
            if (lchild < open_rooms && entry_before(room_heap[lchild], room_heap[best])) begin
               best = lchild;
            end
            if (lchild + 1 < open_rooms &&
                entry_before(room_heap[lchild + 1], room_heap[best])) begin
               best = lchild + 1;
            end
            if (best == pos) begin
               moving = 1'b0;
            end else begin
               held            = room_heap[pos];
               room_heap[pos]  = room_heap[best];
               room_heap[best] = held;
               pos = best;
            end
         end
      end
      res.in_use = ROOM_OUT_W'(open_rooms);
      if (open_rooms > peak_rooms) begin
         peak_rooms = open_rooms;
      end
      if (last) begin
         open_rooms = 0;
      end
   endtask

   // Presents one request, waits for it to be taken and records what it owes.
   task automatic issue_request(input booking_row_type row);
      room_result_type predicted;
      room_result_type written;
      int              gap;
      gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_start_time <= row.arr;
      req_end_time   <= row.dep;
      req_guest_tag  <= row.tag;
      req_is_last    <= row.last;
      @(posedge clock);
      while (busy) @(posedge clock);
      assign_room(row.arr, row.dep, row.tag, row.last, predicted);
      if (row.typed) begin
         written = '{row.tag, row.room, row.in_use, row.ovf, row.last};
         pending_results.push_back(written);
      end else begin
         pending_results.push_back(predicted);
      end
      request_count++;
      if (row.last) begin
         batch_count++;
      end
   endtask

   // Puts the batch in start-then-end order.
   task automatic sort_batch();
      booking_row_type key;
      int              j;
      for (int i = 1; i < booking_batch.size(); i++) begin
         key = booking_batch[i];
         j = i - 1;
         while (j >= 0 && row_after(booking_batch[j], key)) begin
            booking_batch[j + 1] = booking_batch[j];
            j--;
         end
         booking_batch[j + 1] = key;
      end
   endtask

   // A small random batch: sorted, sorted with two rows swapped, or noise.
   task automatic build_small_batch();
      booking_row_type row;
      booking_row_type held;
      batch_kind_type  kind;
      logic [31:0]     cursor;
      int              size;
      int              pick;
      int              a;
      int              b;
      pick = $urandom_range(0, 19);
      kind = (pick < 15) ? BATCH_SORTED : (pick < 17) ? BATCH_BROKEN : BATCH_NOISE;
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
         0: begin
            cursor = '0;
         end
         1: begin
            cursor = TIME_MAX - $urandom_range(0, 200);
         end
         default: begin
            cursor = $urandom;
         end
      endcase
      booking_batch.delete();
      for (int i = 0; i < size; i++) begin
         row = '0;
         row.tag = 16'($urandom);
         if (kind == BATCH_NOISE) begin
            row.arr = $urandom;
            row.dep = ($urandom_range(0, 5) == 0) ? row.arr : $urandom;
         end else begin
            cursor  = time_add(cursor, $urandom_range(0, 6));
            row.arr = cursor;
            row.dep = ($urandom_range(0, 9) == 0) ? time_add(cursor, $urandom_range(0, 1000))
                                                  : time_add(cursor, $urandom_range(0, 12));
         end
         booking_batch.push_back(row);
      end
      if (kind != BATCH_NOISE) begin
         sort_batch();
      end
      if (kind == BATCH_BROKEN && size > 1) begin
         a = $urandom_range(0, size - 1);
         b = $urandom_range(0, size - 1);
         held = booking_batch[a];
         booking_batch[a] = booking_batch[b];
         booking_batch[b] = held;
      end
      booking_batch[size - 1].last = 1'b1;
   endtask

   // A batch where every request overlaps the others, so all rooms fill up
   // and the rest overflow; optionally followed by requests that reuse rooms.
   task automatic build_full_batch(input bit with_reuse);
      booking_row_type row;
      logic [31:0]     base;
      logic [31:0]     cursor;
      int              extra;
      int              reuse;
      base   = $urandom_range(0, 32'h7FFF_FFFF);
      cursor = base;
      extra  = $urandom_range(2, 3);
      reuse  = with_reuse ? $urandom_range(8, 16) : 0;
      booking_batch.delete();
      for (int i = 0; i < MAX_ROOMS + extra; i++) begin
         row = '0;
         row.tag = 16'($urandom);
         cursor  = cursor + $urandom_range(0, 1);
         row.arr = cursor;
         row.dep = base + 1000 + $urandom_range(0, 500);
         booking_batch.push_back(row);
      end
      cursor = base + 1600;
      for (int i = 0; i < reuse; i++) begin
         row = '0;
         row.tag = 16'($urandom);
         cursor  = cursor + $urandom_range(0, 3);
         row.arr = cursor;
         row.dep = cursor + $urandom_range(0, 50);
         booking_batch.push_back(row);
      end
      sort_batch();
      booking_batch[booking_batch.size() - 1].last = 1'b1;
   endtask

   // Checks each result strobe against the oldest expectation.
   always @(posedge clock) begin
      room_result_type want;
      if (!reset && rsp_valid) begin
         result_count++;
         if (rsp_overflow) begin
            overflow_count++;
         end
         if (pending_results.size() == 0) begin
            $error("Result with tag %0h arrived with no request outstanding.", rsp_tag_out);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tag_out !== want.tag) begin
               $error("rsp_tag_out: expected %0h, got %0h", want.tag, rsp_tag_out);
               failures++;
            end
            if (rsp_room_number !== want.room) begin
               $error("rsp_room_number: expected %0d, got %0d", want.room, rsp_room_number);
               failures++;
            end
            if (rsp_rooms_in_use !== want.in_use) begin
               $error("rsp_rooms_in_use: expected %0d, got %0d", want.in_use,
                      rsp_rooms_in_use);
               failures++;
            end
            if (rsp_overflow !== want.ovf) begin
               $error("rsp_overflow: expected %0b, got %0b", want.ovf, rsp_overflow);
               failures++;
            end
            if (rsp_last_out !== want.last) begin
               $error("rsp_last_out: expected %0b, got %0b", want.last, rsp_last_out);
               failures++;
            end
         end
      end
   end

   // Ends the run if neither a request nor a result moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("interval_room_allocator verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reset, directed table, random batches, drain and verdict.
   initial begin
      int random_items;
      int batch_index;
      failures       = 0;
      request_count  = 0;
      result_count   = 0;
      overflow_count = 0;
      batch_count    = 0;
      peak_rooms     = 0;
      open_rooms     = 0;
      no_gaps        = 1'b0;
      idle_cycles    <= 0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_start_time <= '0;
      req_end_time   <= '0;
      req_guest_tag  <= '0;
      req_is_last    <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests, each checked against its row or the predictor.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         issue_request(directed_plan[i]);
      end

      // Random batches; two of them fill every room.
      random_items = 0;
      batch_index  = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (batch_index == 4) begin
            build_full_batch(1'b0);
         end else if (batch_index == 18) begin
            build_full_batch(1'b1);
         end else begin
            build_small_batch();
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         foreach (booking_batch[i]) begin
            issue_request(booking_batch[i]);
         end
         random_items += booking_batch.size();
         batch_index++;
      end
      start <= 1'b0;

      // Let the last results come out, then look for stray strobes.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests in %0d batches and checked %0d results.",
               request_count, batch_count, result_count);
      $display("Saw %0d overflow results; the fullest batch opened %0d rooms.",
               overflow_count, peak_rooms);
      if (failures == 0) begin
         $display("interval_room_allocator verification clean");
      end else begin
         $display("interval_room_allocator verification failed");
      end
      $finish;
   end

endmodule
